>>> hdl/srm_pkg.sv
// Shared types and constants for the soft reversing motor ramp.
// Used by srm_scaler and soft_reversing_motor_ramp_top; depends on nothing.
`default_nettype none

package srm_pkg;

  localparam int SRM_DUTY_BITS = 16;   // default duty register width
  localparam int SRM_WORD_W    = 16;   // width of readings, limits and steps
  localparam int SRM_SCL_STEPS = SRM_WORD_W;
  localparam int SRM_CNT_W     = $clog2(SRM_SCL_STEPS);
  localparam int SRM_ADDR_W    = 4;
  localparam int SRM_DATA_W    = 32;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_DUTY_STEP     = 2'd0;
  localparam logic [1:0] REG_DUTY_LIMIT    = 2'd1;
  localparam logic [1:0] REG_READING_LIMIT = 2'd2;

  localparam logic [SRM_WORD_W-1:0] RST_DUTY_STEP     = 16'd1;
  localparam logic [SRM_WORD_W-1:0] RST_DUTY_LIMIT    = 16'd255;
  localparam logic [SRM_WORD_W-1:0] RST_READING_LIMIT = 16'd1023;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } srm_state_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV
  } srm_scl_e;

  typedef struct packed {
    logic busy;
    logic done;
  } srm_scl_sts_t;

endpackage

`default_nettype wire

>>> hdl/soft_reversing_motor_ramp_top.sv
// Soft-start H-bridge duty ramp with direction reversal, top level.
// Uses srm_pkg and srm_scaler.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid / tready           tdata: button, pot reading, brake
//  m_axis    out  tvalid / tready           tdata: duty, left, right, led
//  apb       in   psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// An accepted item passes through a bit-serial multiply and a restoring divide
// in srm_scaler, then through the state update that loads the output register.
// Reset clears the state to forward heading, zero duty, bridge off.
// A result stalled at m_axis does not block acceptance of the next item; the
// update of that next item waits until the output register is free.
`default_nettype none

module soft_reversing_motor_ramp_top #(
  parameter int DUTY_BITS = srm_pkg::SRM_DUTY_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] dir_button_level, [16:1] pot_reading, [17] brake_request, [23:18] zero
  input  wire logic [23:0]                    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [15:0] pwm_duty, [16] drive_left, [17] drive_right, [18] led_pulse, [23:19] zero
  output logic      [23:0]                    m_axis_tdata,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [srm_pkg::SRM_ADDR_W-1:0] paddr,
  input  wire logic [srm_pkg::SRM_DATA_W-1:0] pwdata,
  output logic      [srm_pkg::SRM_DATA_W-1:0] prdata,
  output logic                                pready
);
  import srm_pkg::*;

  localparam int W  = SRM_WORD_W;
  localparam int CW = ((DUTY_BITS > W) ? DUTY_BITS : W) + 1;
  localparam logic [CW-1:0] DUTY_MAX = CW'({DUTY_BITS{1'b1}});

  // configuration
  logic [W-1:0] step_q, dlim_q, rlim_q;
  logic         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= RST_DUTY_STEP;
      dlim_q <= RST_DUTY_LIMIT;
      rlim_q <= RST_READING_LIMIT;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DUTY_STEP:     step_q <= pwdata[W-1:0];
        REG_DUTY_LIMIT:    dlim_q <= pwdata[W-1:0];
        REG_READING_LIMIT: rlim_q <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DUTY_STEP:     prdata = SRM_DATA_W'(step_q);
      REG_DUTY_LIMIT:    prdata = SRM_DATA_W'(dlim_q);
      REG_READING_LIMIT: prdata = SRM_DATA_W'(rlim_q);
      default:           prdata = '0;
    endcase
  end

  // control sequencing
  srm_state_e   state_q, state_d;
  logic         in_acc;
  logic         scl_start;
  logic         fin_go;
  srm_scl_sts_t scl_sts;
  logic [W-1:0] scl_quot;

  assign in_acc = s_axis_tvalid & s_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_CALC;
      ST_CALC: if (scl_sts.done)  state_d = ST_FIN;
      ST_FIN:  if (!m_axis_tvalid || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    scl_start     = in_acc;
    fin_go        = (state_q == ST_FIN) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  srm_scaler u_scaler (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (scl_start),
    .reading_i       (s_axis_tdata[16:1]),
    .duty_limit_i    (dlim_q),
    .reading_limit_i (rlim_q),
    .sts_o           (scl_sts),
    .quot_o          (scl_quot)
  );

  // held item flags
  logic btn_level_q, brake_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      btn_level_q <= s_axis_tdata[0];
      brake_q     <= s_axis_tdata[17];
    end
  end

  // motor state
  logic                 prev_pressed_q, prev_pressed_d;
  logic                 heading_q, heading_d;
  logic                 rev_done_q, rev_done_d;
  logic                 accel_q, accel_d;
  logic [DUTY_BITS-1:0] duty_q, duty_d;
  logic                 br_l_q, br_l_d;
  logic                 br_r_q, br_r_d;

  logic                 pressed, toggle, rev_mid;
  logic [W-1:0]         target;
  logic [CW-1:0]        duty_x, tgt_x, dlim_x, step_x, top_x;
  logic [CW-1:0]        up_x, dn_x, new_x;

  always_comb begin
    pressed        = ~btn_level_q;
    toggle         = pressed & ~prev_pressed_q;
    prev_pressed_d = pressed;
    heading_d      = heading_q ^ toggle;
    // a heading change holds the bridge until the duty reaches zero
    rev_mid        = rev_done_q & ~toggle;

    br_l_d = br_l_q;
    br_r_d = br_r_q;
    target = '0;
    if (rev_mid) begin
      br_r_d = heading_d;
      br_l_d = ~heading_d;
      target = scl_quot;
    end
    if (brake_q) begin
      br_l_d = 1'b1;
      br_r_d = 1'b1;
      target = '0;
    end

    duty_x = CW'(duty_q);
    tgt_x  = CW'(target);
    dlim_x = CW'(dlim_q);
    step_x = CW'(step_q);

    if (duty_x > tgt_x) begin
      accel_d = 1'b0;
    end else if (duty_x < tgt_x) begin
      accel_d = 1'b1;
    end else begin
      accel_d = accel_q;
    end

    top_x = (tgt_x < dlim_x) ? tgt_x : dlim_x;
    if (top_x > DUTY_MAX) begin
      top_x = DUTY_MAX;
    end
    up_x = duty_x + step_x;
    dn_x = (duty_x > step_x) ? (duty_x - step_x) : '0;

    new_x      = duty_x;
    rev_done_d = rev_mid;
    if (accel_d) begin
      if (duty_x < top_x) begin
        new_x = (up_x > top_x) ? top_x : up_x;
      end
    end else begin
      if (duty_x != '0) begin
        new_x = (dn_x < tgt_x) ? tgt_x : dn_x;
      end else begin
        rev_done_d = 1'b1;
      end
    end
    duty_d = new_x[DUTY_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pressed_q <= 1'b0;
      heading_q      <= 1'b1;
      rev_done_q     <= 1'b1;
      accel_q        <= 1'b0;
      duty_q         <= '0;
      br_l_q         <= 1'b0;
      br_r_q         <= 1'b0;
    end else if (fin_go) begin
      prev_pressed_q <= prev_pressed_d;
      heading_q      <= heading_d;
      rev_done_q     <= rev_done_d;
      accel_q        <= accel_d;
      duty_q         <= duty_d;
      br_l_q         <= br_l_d;
      br_r_q         <= br_r_d;
    end
  end

  // output register
  logic         out_valid_q;
  logic [W-1:0] out_duty_q;
  logic         out_l_q, out_r_q, out_led_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_duty_q <= new_x[W-1:0];
      out_l_q    <= br_l_d;
      out_r_q    <= br_r_d;
      out_led_q  <= toggle;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_led_q, out_r_q, out_l_q, out_duty_q};

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scl_start |-> !scl_sts.busy)
    else $error("scaler started while busy");

  a_done_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scl_sts.done |-> (state_q == ST_CALC))
    else $error("scaler finished outside of the calc state");

  a_led_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && toggle) |=> (heading_q != $past(heading_q)))
    else $error("led pulse without heading change");
`endif

endmodule

`default_nettype wire

>>> hdl/srm_scaler.sv
// Bit-serial scaler: min(reading, rl) * dl / rl, one bit per cycle.
// Shift-add multiply then restoring divide on one shared register pair; uses srm_pkg.
`default_nettype none

module srm_scaler (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [srm_pkg::SRM_WORD_W-1:0] reading_i,
  input  wire logic [srm_pkg::SRM_WORD_W-1:0] duty_limit_i,
  input  wire logic [srm_pkg::SRM_WORD_W-1:0] reading_limit_i,
  output srm_pkg::srm_scl_sts_t               sts_o,
  output logic      [srm_pkg::SRM_WORD_W-1:0] quot_o
);
  import srm_pkg::*;

  localparam int W = SRM_WORD_W;
  localparam logic [SRM_CNT_W-1:0] LAST_STEP = SRM_CNT_W'(SRM_SCL_STEPS - 1);

  srm_scl_e             phase_q, phase_d;
  logic [SRM_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [W-1:0]         hi_q, hi_d;
  logic [W-1:0]         lo_q, lo_d;
  logic [W-1:0]         mcand_q, mcand_d;
  logic [W-1:0]         div_q, div_d;

  logic [W:0]           add_sum;
  logic [W:0]           add_sel;
  logic [W:0]           trial;
  logic [W+1:0]         diff;
  logic                 fits;

  always_comb begin
    add_sum = {1'b0, hi_q} + {1'b0, mcand_q};
    add_sel = lo_q[0] ? add_sum : {1'b0, hi_q};
    trial   = {hi_q, lo_q[W-1]};
    diff    = {1'b0, trial} - {2'b00, div_q};
    fits    = ~diff[W+1];
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    hi_d    = hi_q;
    lo_d    = lo_q;
    mcand_d = mcand_q;
    div_d   = div_q;
    unique case (phase_q)
      SC_IDLE: begin
        if (start_i) begin
          phase_d = SC_MUL;
          cnt_d   = '0;
          hi_d    = '0;
          lo_d    = (reading_i > reading_limit_i) ? reading_limit_i : reading_i;
          mcand_d = duty_limit_i;
          div_d   = reading_limit_i;
        end
      end
      SC_MUL: begin
        // add multiplicand on a set multiplier bit, shift the pair right
        hi_d  = add_sel[W:1];
        lo_d  = {add_sel[0], lo_q[W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          phase_d = SC_DIV;
        end
      end
      SC_DIV: begin
        // high half stays below the divisor, so quotient fits the low half
        hi_d  = fits ? diff[W-1:0] : trial[W-1:0];
        lo_d  = {lo_q[W-2:0], fits};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          phase_d = SC_IDLE;
          done_d  = 1'b1;
        end
      end
      default: phase_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= SC_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    mcand_q <= mcand_d;
    div_q   <= div_d;
  end

  assign sts_o.busy = (phase_q != SC_IDLE);
  assign sts_o.done = done_q;
  // a zero full-scale reading gives a zero target
  assign quot_o     = (div_q == '0) ? '0 : lo_q;

endmodule

`default_nettype wire

>>> tb/tb_soft_reversing_motor_ramp_top.sv
// Self-checking testbench for soft_reversing_motor_ramp_top: ramp, reversal and brake.
// A scoreboard class predicts each tick's result and compares it with the m_axis output.
// Depends on srm_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module tb_soft_reversing_motor_ramp_top;
  import srm_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 150;

  // result fields, highest bit first as on m_axis_tdata
  typedef struct packed {
    logic        led;
    logic        drv_right;
    logic        drv_left;
    logic [15:0] duty;
  } ramp_result_t;

  class ramp_scoreboard;
    int unsigned     step_cfg;
    int unsigned     limit_cfg;
    int unsigned     span_cfg;
    bit              prev_pressed;
    bit              fwd;
    bit              last_fwd;
    bit              rev_done;
    bit              accel;
    bit              drv_left;
    bit              drv_right;
    longint unsigned duty;
    ramp_result_t    expected_q[$];
    int              errors;

    function new();
      step_cfg     = 32'(RST_DUTY_STEP);
      limit_cfg    = 32'(RST_DUTY_LIMIT);
      span_cfg     = 32'(RST_READING_LIMIT);
      prev_pressed = 1'b0;
      fwd          = 1'b1;
      last_fwd     = 1'b1;
      rev_done     = 1'b1;
      accel        = 1'b0;
      drv_left     = 1'b0;
      drv_right    = 1'b0;
      duty         = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_DUTY_STEP:     step_cfg  = 32'(val);
        REG_DUTY_LIMIT:    limit_cfg = 32'(val);
        REG_READING_LIMIT: span_cfg  = 32'(val);
        default: ;
      endcase
    endfunction

    // Advance the predicted controller by one tick and queue its result.
    function void note_tick(bit level, logic [15:0] pot, bit brake);
      longint unsigned target;
      longint unsigned reading;
      longint unsigned top;
      longint unsigned nxt;
      ramp_result_t    r;
      target = '0;
      r.led  = 1'b0;
      if (!level && !prev_pressed) begin
        r.led = 1'b1;
        fwd   = !fwd;
      end
      prev_pressed = !level;
      if (fwd != last_fwd) rev_done = 1'b0;
      last_fwd = fwd;
      if (rev_done) begin
        drv_right = fwd;
        drv_left  = !fwd;
        if (span_cfg != 0) begin
          reading = (pot > span_cfg) ? 64'(span_cfg) : 64'(pot);
          target  = reading * limit_cfg / span_cfg;
        end
      end
      if (brake) begin
        drv_left  = 1'b1;
        drv_right = 1'b1;
        target    = '0;
      end
      if (duty > target) accel = 1'b0;
      else if (duty < target) accel = 1'b1;
      if (accel) begin
        top = (target > limit_cfg) ? 64'(limit_cfg) : target;
        if (duty < top) begin
          nxt  = duty + step_cfg;
          duty = (nxt > top) ? top : nxt;
        end
      end else if (duty > 0) begin
        nxt  = (duty > step_cfg) ? duty - step_cfg : '0;
        duty = (nxt < target) ? target : nxt;
      end else begin
        rev_done = 1'b1;
      end
      r.duty      = duty[15:0];
      r.drv_left  = drv_left;
      r.drv_right = drv_right;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [23:0] data);
      ramp_result_t got;
      ramp_result_t want;
      got = data[18:0];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: tdata=%h", data);
        return;
      end
      want = expected_q.pop_front();
      if (got.duty !== want.duty || got.drv_left !== want.drv_left ||
          got.drv_right !== want.drv_right || got.led !== want.led) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: duty %0d/%0d left %b/%b right %b/%b led %b/%b (exp/act)",
                   want.duty, got.duty, want.drv_left, got.drv_left,
                   want.drv_right, got.drv_right, want.led, got.led);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [0] dir_button_level, [16:1] pot_reading, [17] brake_request, [23:18] zero
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [15:0] pwm_duty, [16] drive_left, [17] drive_right, [18] led_pulse, [23:19] zero
  logic [23:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [SRM_ADDR_W-1:0] paddr;
  logic [SRM_DATA_W-1:0] pwdata;
  logic [SRM_DATA_W-1:0] prdata;
  logic        pready;

  ramp_scoreboard sb = new();
  bit             tx_idle;
  bit             rx_idle;
  int             idle_cycles = 0;

  soft_reversing_motor_ramp_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Drain results, stalling at random when rx_idle is set.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = rx_idle ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  // Abort when nothing moves on either stream for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Enter and leave at a falling edge; valid stays high when no gap follows.
  task automatic send_tick(input bit level, input logic [15:0] pot, input bit brake);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {6'd0, brake, pot, level};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(level, pot, brake);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Called at a falling edge: drop valid, wait for all results, then reprogram.
  task automatic apply_settings(input logic [15:0] step, input logic [15:0] limit,
                                input logic [15:0] span);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    write_reg(REG_DUTY_STEP, step);
    write_reg(REG_DUTY_LIMIT, limit);
    write_reg(REG_READING_LIMIT, span);
  endtask

  initial begin
    bit          btn;
    bit          brk;
    logic [15:0] pot;
    int          brake_run;
    int unsigned lim;
    int unsigned span;
    int unsigned step;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: reading extremes, brake, press, hold and release
    send_tick(1'b1, 16'd0, 1'b0);
    send_tick(1'b1, 16'hFFFF, 1'b0);
    send_tick(1'b1, 16'd1023, 1'b0);
    send_tick(1'b1, 16'd1023, 1'b1);
    send_tick(1'b0, 16'd1024, 1'b0);
    send_tick(1'b0, 16'd1023, 1'b0);
    send_tick(1'b1, 16'd1022, 1'b0);
    send_tick(1'b0, 16'd0, 1'b1);

    // full-scale step: one-tick ramps, then a complete reversal
    apply_settings(16'hFFFF, 16'hFFFF, 16'd1);
    send_tick(1'b1, 16'd1, 1'b0);
    send_tick(1'b1, 16'd0, 1'b0);
    send_tick(1'b1, 16'd2, 1'b0);
    send_tick(1'b0, 16'd1, 1'b0);
    send_tick(1'b0, 16'd1, 1'b0);
    send_tick(1'b1, 16'd1, 1'b0);
    send_tick(1'b1, 16'd1, 1'b1);
    send_tick(1'b0, 16'hFFFF, 1'b1);

    // zero step and zero reading span
    apply_settings(16'd0, 16'd255, 16'd0);
    send_tick(1'b1, 16'd500, 1'b0);
    send_tick(1'b0, 16'd500, 1'b0);
    send_tick(1'b1, 16'd500, 1'b1);
    send_tick(1'b1, 16'd0, 1'b0);
    send_tick(1'b0, 16'hFFFF, 1'b0);

    btn       = 1'b1;
    pot       = '0;
    brake_run = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin step = 1;     lim = 255;   span = 1023;  end
        1: begin step = 65535; lim = 65535; span = 65535; end
        2: begin step = 1;     lim = 1;     span = 1;     end
        3: begin step = 2;     lim = 100;   span = 1;     end
        default: begin
          lim  = $urandom_range(1, 65535);
          span = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 255)
                                             : $urandom_range(1, 65535);
          step = lim / $urandom_range(1, 60) + 1;
          if (step > 65535) step = 65535;
          step = $urandom_range(1, step);
        end
      endcase
      apply_settings(step[15:0], lim[15:0], span[15:0]);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 15) == 0) btn = !btn;
        // hold the reading mostly steady so ramps settle on a target
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 7))
            0:       pot = 16'd0;
            1:       pot = span[15:0];
            2:       pot = 16'hFFFF;
            3, 4:    pot = 16'($urandom_range(0, 65535));
            default: pot = 16'($urandom_range(0, span));
          endcase
        end
        if (brake_run == 0 && $urandom_range(0, 39) == 0) brake_run = $urandom_range(1, 8);
        brk = (brake_run > 0);
        if (brake_run > 0) brake_run--;
        send_tick(btn, pot, brk);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
hdl/srm_pkg.sv
hdl/srm_scaler.sv
hdl/soft_reversing_motor_ramp_top.sv
tb/tb_soft_reversing_motor_ramp_top.sv
